// ===== rtl/ttk_pkg.sv =====
// Shared types and constants for the TTK-91 execute unit.
// Used by the front end, the queue and the back end.
package ttk_pkg;

  localparam int unsigned PC_W = 10;

  typedef logic [7:0] opc_t;

  localparam opc_t OP_NOP   = 8'd0;
  localparam opc_t OP_STORE = 8'd1;
  localparam opc_t OP_LOAD  = 8'd2;
  localparam opc_t OP_IN    = 8'd3;
  localparam opc_t OP_OUT   = 8'd4;
  localparam opc_t OP_ADD   = 8'd17;
  localparam opc_t OP_SUB   = 8'd18;
  localparam opc_t OP_MUL   = 8'd19;
  localparam opc_t OP_DIV   = 8'd20;
  localparam opc_t OP_MOD   = 8'd21;
  localparam opc_t OP_AND   = 8'd22;
  localparam opc_t OP_OR    = 8'd23;
  localparam opc_t OP_XOR   = 8'd24;
  localparam opc_t OP_SHL   = 8'd25;
  localparam opc_t OP_SHR   = 8'd26;
  localparam opc_t OP_NOT   = 8'd27;
  localparam opc_t OP_SHRA  = 8'd28;
  localparam opc_t OP_COMP  = 8'd31;
  localparam opc_t OP_JUMP  = 8'd32;
  localparam opc_t OP_JNEG  = 8'd33;
  localparam opc_t OP_JZER  = 8'd34;
  localparam opc_t OP_JPOS  = 8'd35;
  localparam opc_t OP_JNNEG = 8'd36;
  localparam opc_t OP_JNZER = 8'd37;
  localparam opc_t OP_JNPOS = 8'd38;
  localparam opc_t OP_JLES  = 8'd39;
  localparam opc_t OP_JEQU  = 8'd40;
  localparam opc_t OP_JGRE  = 8'd41;
  localparam opc_t OP_JNLES = 8'd42;
  localparam opc_t OP_JNEQU = 8'd43;
  localparam opc_t OP_JNGRE = 8'd44;
  localparam opc_t OP_CALL  = 8'd49;
  localparam opc_t OP_EXIT  = 8'd50;
  localparam opc_t OP_PUSH  = 8'd51;
  localparam opc_t OP_POP   = 8'd52;
  localparam opc_t OP_PUSHR = 8'd53;
  localparam opc_t OP_POPR  = 8'd54;
  localparam opc_t OP_SVC   = 8'd112;

  localparam logic [15:0] HALT_CODE = 16'd11;
  localparam logic [2:0]  SP_IDX    = 3'd6;
  localparam logic [2:0]  FP_IDX    = 3'd7;
  localparam logic [1:0]  MODE_DIR  = 2'd1;
  localparam logic [1:0]  MODE_IND  = 2'd2;

  typedef struct packed {
    logic        preload;
    logic        known;
    opc_t        opc;
    logic [2:0]  rj;
    logic [1:0]  mode;
    logic [2:0]  ri;
    logic [15:0] addr;
    logic [31:0] in_value;
    logic [9:0]  pl_addr;
    logic [31:0] pl_data;
  } item_t;

  function automatic logic known_op(input opc_t o);
    logic k;
    k = (o <= OP_OUT) || (o >= OP_ADD && o <= OP_SHRA) ||
        (o >= OP_COMP && o <= OP_JNGRE) || (o >= OP_CALL && o <= OP_POPR) ||
        (o == OP_SVC);
    return k;
  endfunction

endpackage

// ===== rtl/ttk_in_if.sv =====
// Input channel of the TTK-91 execute unit: valid/ready plus item fields.
// Standalone; no package dependency.
interface ttk_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instr_word;
  logic signed [31:0] in_value;
  logic [9:0]  preload_addr;
  logic signed [31:0] preload_data;

  modport source(output valid, operation, instr_word, in_value, preload_addr,
                 preload_data, input ready);
  modport sink(input valid, operation, instr_word, in_value, preload_addr,
               preload_data, output ready);
endinterface

// ===== rtl/ttk_out_if.sv =====
// Result channel of the TTK-91 execute unit: valid/ready plus result fields.
// Standalone; no package dependency.
interface ttk_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  next_pc;
  logic        out_valid;
  logic signed [31:0] out_value;
  logic        halted;
  logic        flag_greater;
  logic        flag_equal;
  logic        flag_less;
  logic        unknown_opcode;
  logic        divide_by_zero;

  modport source(output valid, next_pc, out_valid, out_value, halted, flag_greater,
                 flag_equal, flag_less, unknown_opcode, divide_by_zero, input ready);
  modport sink(input valid, next_pc, out_valid, out_value, halted, flag_greater,
               flag_equal, flag_less, unknown_opcode, divide_by_zero, output ready);
endinterface

// ===== rtl/ttk_front.sv =====
// Front end: accepts items, splits the instruction word and classifies it.
// Depends on ttk_pkg and ttk_in_if.
module ttk_front (
  input  logic           clk,
  input  logic           rst_n,
  ttk_in_if.sink         in_ch,
  output logic           push,
  output ttk_pkg::item_t push_item,
  input  logic           q_ready
);

  logic           fr_valid_r;
  ttk_pkg::item_t fr_item_r;
  ttk_pkg::item_t dec;
  logic           acc;

  assign in_ch.ready = !fr_valid_r || q_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push        = fr_valid_r && q_ready;
  assign push_item   = fr_item_r;

  always_comb begin
    dec.preload  = in_ch.operation;
    dec.opc      = in_ch.instr_word[31:24];
    dec.known    = ttk_pkg::known_op(in_ch.instr_word[31:24]);
    dec.rj       = in_ch.instr_word[23:21];
    dec.mode     = in_ch.instr_word[20:19];
    dec.ri       = in_ch.instr_word[18:16];
    dec.addr     = in_ch.instr_word[15:0];
    dec.in_value = in_ch.in_value;
    dec.pl_addr  = in_ch.preload_addr;
    dec.pl_data  = in_ch.preload_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (acc) begin
      fr_valid_r <= 1'b1;
    end else if (push) begin
      fr_valid_r <= 1'b0;
    end
    if (acc) begin
      fr_item_r <= dec;
    end
  end

endmodule

// ===== rtl/ttk_queue.sv =====
// Two-entry queue of decoded items between front and back end.
// Depends on ttk_pkg.
module ttk_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttk_pkg::item_t push_item,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output ttk_pkg::item_t q_item
);

  ttk_pkg::item_t ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/ttk_back.sv =====
// Back end: register file, data memory, divider and sequencer per instruction.
// Depends on ttk_pkg and ttk_out_if.
module ttk_back #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ttk_pkg::item_t q_item,
  output logic           pop,
  ttk_out_if.source      out_ch
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [4:0] {
    S_IDLE, S_RI, S_RJ, S_MRD, S_MCAP, S_EXEC, S_DIV, S_DIVW, S_POPD, S_POPS,
    S_CALL2, S_CALL3, S_EXIT1, S_EXIT2, S_PSHR, S_POPR_RD, S_POPR_WR, S_DONE
  } state_t;

  state_t         state_r;
  ttk_pkg::item_t cur_r;
  logic [31:0]    x_r, a_r, mb_r, quo_r, rem_r;
  logic [4:0]     cnt_r;
  logic           rd2_r;
  logic [9:0]     pc_r;
  logic [2:0]     flags_r;
  logic           unk_r, halt_r, dbz_r, res_ov_r;
  logic [31:0]    res_oval_r;
  logic           ov_r;

  logic [31:0]    rf_r [8];
  logic [2:0]     rf_ra, rf_wa;
  logic           rf_we;
  logic [31:0]    rf_wd, rf_rd;

  logic [31:0]    mem [MEM_WORDS];
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_a;
  logic [31:0]    mem_wd, rdata_r;

  logic [31:0]    sp, fp, alu, divres, sext, mag_a, mag_x;
  logic [31:0]    sp_p1, sp_p2, fp_m1;
  logic [9:0]     pc_inc;
  logic           jmp;
  logic [32:0]    rem_sh, diff;
  logic [31:0]    pl_a32;

  assign sp     = rf_r[ttk_pkg::SP_IDX];
  assign fp     = rf_r[ttk_pkg::FP_IDX];
  assign sp_p1  = sp + 32'd1;
  assign sp_p2  = sp + 32'd2;
  assign fp_m1  = fp - 32'd1;
  assign rf_rd  = rf_r[rf_ra];
  assign pc_inc = pc_r + 10'd1;
  assign sext   = {{16{cur_r.addr[15]}}, cur_r.addr};
  assign mag_a  = a_r[31] ? (32'd0 - a_r) : a_r;
  assign mag_x  = x_r[31] ? (32'd0 - x_r) : x_r;
  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, mb_r};
  assign pl_a32 = {22'd0, q_item.pl_addr};
  assign pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    unique case (cur_r.opc)
      ttk_pkg::OP_ADD:  alu = a_r + x_r;
      ttk_pkg::OP_SUB:  alu = a_r - x_r;
      ttk_pkg::OP_MUL:  alu = a_r * x_r;
      ttk_pkg::OP_AND:  alu = a_r & x_r;
      ttk_pkg::OP_OR:   alu = a_r | x_r;
      ttk_pkg::OP_XOR:  alu = a_r ^ x_r;
      ttk_pkg::OP_SHL:  alu = (|x_r[31:5]) ? 32'd0 : (a_r << x_r[4:0]);
      ttk_pkg::OP_SHR:  alu = (|x_r[31:5]) ? 32'd0 : (a_r >> x_r[4:0]);
      ttk_pkg::OP_NOT:  alu = ~a_r;
      ttk_pkg::OP_SHRA: alu = $signed(a_r) >>> ((|x_r[31:5]) ? 5'd31 : x_r[4:0]);
      ttk_pkg::OP_LOAD: alu = x_r;
      default:          alu = cur_r.in_value;
    endcase
    if (cur_r.opc == ttk_pkg::OP_DIV) begin
      divres = (a_r[31] ^ x_r[31]) ? (32'd0 - quo_r) : quo_r;
    end else begin
      divres = a_r[31] ? (32'd0 - rem_r) : rem_r;
    end
    unique case (cur_r.opc)
      ttk_pkg::OP_JUMP:  jmp = 1'b1;
      ttk_pkg::OP_JNEG:  jmp = a_r[31];
      ttk_pkg::OP_JZER:  jmp = (a_r == 32'd0);
      ttk_pkg::OP_JPOS:  jmp = !a_r[31] && (a_r != 32'd0);
      ttk_pkg::OP_JNNEG: jmp = !a_r[31];
      ttk_pkg::OP_JNZER: jmp = (a_r != 32'd0);
      ttk_pkg::OP_JNPOS: jmp = a_r[31] || (a_r == 32'd0);
      ttk_pkg::OP_JLES:  jmp = flags_r[0];
      ttk_pkg::OP_JEQU:  jmp = flags_r[1];
      ttk_pkg::OP_JGRE:  jmp = flags_r[2];
      ttk_pkg::OP_JNLES: jmp = !flags_r[0];
      ttk_pkg::OP_JNEQU: jmp = !flags_r[1];
      ttk_pkg::OP_JNGRE: jmp = !flags_r[2];
      default:           jmp = 1'b0;
    endcase
  end

  always_comb begin
    rf_ra  = cur_r.ri;
    rf_we  = 1'b0;
    rf_wa  = cur_r.rj;
    rf_wd  = alu;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_a  = x_r[AW-1:0];
    mem_wd = a_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.preload) begin
          mem_we = 1'b1;
          mem_a  = pl_a32[AW-1:0];
          mem_wd = q_item.pl_data;
        end
      end
      S_RJ: rf_ra = cur_r.rj;
      S_MRD: mem_re = 1'b1;
      S_EXEC: begin
        unique case (cur_r.opc)
          ttk_pkg::OP_STORE: mem_we = 1'b1;
          ttk_pkg::OP_LOAD, ttk_pkg::OP_IN, ttk_pkg::OP_ADD, ttk_pkg::OP_SUB,
          ttk_pkg::OP_MUL, ttk_pkg::OP_AND, ttk_pkg::OP_OR, ttk_pkg::OP_XOR,
          ttk_pkg::OP_SHL, ttk_pkg::OP_SHR, ttk_pkg::OP_NOT, ttk_pkg::OP_SHRA:
            rf_we = 1'b1;
          ttk_pkg::OP_PUSH: begin
            mem_we = 1'b1;
            mem_a  = sp_p1[AW-1:0];
            mem_wd = x_r;
            rf_we  = 1'b1;
            rf_wa  = ttk_pkg::SP_IDX;
            rf_wd  = sp_p1;
          end
          ttk_pkg::OP_POP: begin
            mem_re = 1'b1;
            mem_a  = sp[AW-1:0];
          end
          ttk_pkg::OP_CALL: begin
            mem_we = 1'b1;
            mem_a  = sp_p1[AW-1:0];
            mem_wd = {22'd0, pc_inc};
          end
          ttk_pkg::OP_EXIT: begin
            mem_re = 1'b1;
            mem_a  = fp_m1[AW-1:0];
            rf_we  = 1'b1;
            rf_wa  = ttk_pkg::SP_IDX;
            rf_wd  = fp - 32'd2 - x_r;
          end
          default: ;
        endcase
      end
      S_DIVW: rf_wd = divres;
      S_POPD: begin
        rf_we = 1'b1;
        rf_wa = cur_r.ri;
        rf_wd = rdata_r;
      end
      S_POPS, S_POPR_RD: begin
        rf_we = 1'b1;
        rf_wa = ttk_pkg::SP_IDX;
        rf_wd = sp - 32'd1;
        if (state_r == S_POPR_RD) begin
          mem_re = 1'b1;
          mem_a  = sp[AW-1:0];
        end
      end
      S_CALL2: begin
        mem_we = 1'b1;
        mem_a  = sp_p2[AW-1:0];
        mem_wd = fp;
        rf_we  = 1'b1;
        rf_wa  = ttk_pkg::SP_IDX;
        rf_wd  = sp_p2;
      end
      S_CALL3: begin
        rf_we = 1'b1;
        rf_wa = ttk_pkg::FP_IDX;
        rf_wd = sp;
      end
      S_EXIT1: begin
        mem_re = 1'b1;
        mem_a  = fp[AW-1:0];
      end
      S_EXIT2: begin
        rf_we = 1'b1;
        rf_wa = ttk_pkg::FP_IDX;
        rf_wd = rdata_r;
      end
      S_PSHR: begin
        rf_ra  = cnt_r[2:0];
        mem_we = 1'b1;
        mem_a  = sp_p1[AW-1:0];
        mem_wd = rf_rd;
        rf_we  = 1'b1;
        rf_wa  = ttk_pkg::SP_IDX;
        rf_wd  = sp_p1;
      end
      S_POPR_WR: begin
        rf_we = 1'b1;
        rf_wa = cnt_r[2:0];
        rf_wd = rdata_r;
      end
      default: ;
    endcase
    if (state_r == S_DIVW) begin
      rf_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 32'd0;
      end
    end else if (rf_we) begin
      rf_r[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_a] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      flags_r <= '0;
      unk_r   <= 1'b0;
      halt_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != S_DONE)) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r    <= q_item;
            dbz_r    <= 1'b0;
            res_ov_r <= 1'b0;
            if (q_item.preload || halt_r) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RI;
            end
          end
        end
        S_RI: begin
          x_r     <= sext + ((cur_r.ri != 3'd0) ? rf_rd : 32'd0);
          state_r <= S_RJ;
        end
        S_RJ: begin
          a_r   <= rf_rd;
          rd2_r <= (cur_r.mode == ttk_pkg::MODE_IND);
          if (cur_r.mode == ttk_pkg::MODE_DIR || cur_r.mode == ttk_pkg::MODE_IND) begin
            state_r <= S_MRD;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_MRD: state_r <= S_MCAP;
        S_MCAP: begin
          x_r   <= rdata_r;
          rd2_r <= 1'b0;
          state_r <= rd2_r ? S_MRD : S_EXEC;
        end
        S_EXEC: begin
          pc_r    <= jmp ? x_r[9:0] : pc_inc;
          state_r <= S_DONE;
          unique case (cur_r.opc)
            ttk_pkg::OP_OUT: begin
              res_ov_r   <= 1'b1;
              res_oval_r <= a_r;
            end
            ttk_pkg::OP_DIV, ttk_pkg::OP_MOD: begin
              if (x_r == 32'd0) begin
                dbz_r <= 1'b1;
              end else begin
                quo_r   <= mag_a;
                rem_r   <= 32'd0;
                mb_r    <= mag_x;
                cnt_r   <= 5'd0;
                state_r <= S_DIV;
              end
            end
            ttk_pkg::OP_COMP: begin
              if ($signed(a_r) > $signed(x_r)) begin
                flags_r <= 3'b100;
              end else if (a_r == x_r) begin
                flags_r <= 3'b010;
              end else begin
                flags_r <= 3'b001;
              end
            end
            ttk_pkg::OP_CALL: begin
              pc_r    <= x_r[9:0];
              state_r <= S_CALL2;
            end
            ttk_pkg::OP_EXIT: state_r <= S_EXIT1;
            ttk_pkg::OP_POP:  state_r <= S_POPD;
            ttk_pkg::OP_PUSHR: begin
              cnt_r   <= 5'd0;
              state_r <= S_PSHR;
            end
            ttk_pkg::OP_POPR: begin
              cnt_r   <= 5'd5;
              state_r <= S_POPR_RD;
            end
            ttk_pkg::OP_SVC: begin
              if (cur_r.addr == ttk_pkg::HALT_CODE) begin
                halt_r <= 1'b1;
              end
            end
            default: begin
              if (!cur_r.known) begin
                unk_r <= 1'b1;
              end
            end
          endcase
        end
        S_DIV: begin
          if (!diff[32]) begin
            rem_r <= diff[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh[31:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW:  state_r <= S_DONE;
        S_POPD:  state_r <= S_POPS;
        S_POPS:  state_r <= S_DONE;
        S_CALL2: state_r <= S_CALL3;
        S_CALL3: state_r <= S_DONE;
        S_EXIT1: begin
          pc_r    <= rdata_r[9:0];
          state_r <= S_EXIT2;
        end
        S_EXIT2: state_r <= S_DONE;
        S_PSHR: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd5) begin
            state_r <= S_DONE;
          end
        end
        S_POPR_RD: state_r <= S_POPR_WR;
        S_POPR_WR: begin
          cnt_r   <= cnt_r - 5'd1;
          state_r <= (cnt_r == 5'd0) ? S_DONE : S_POPR_RD;
        end
        S_DONE: begin
          if (!ov_r || out_ch.ready) begin
            ov_r                  <= 1'b1;
            out_ch.next_pc        <= pc_r;
            out_ch.out_valid      <= res_ov_r;
            out_ch.out_value      <= res_ov_r ? res_oval_r : 32'd0;
            out_ch.halted         <= halt_r;
            out_ch.flag_greater   <= flags_r[2];
            out_ch.flag_equal     <= flags_r[1];
            out_ch.flag_less      <= flags_r[0];
            out_ch.unknown_opcode <= unk_r;
            out_ch.divide_by_zero <= dbz_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ov_r;

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n) !$fell(halt_r))
    else $error("halt flag cleared");
  a_unk_sticky: assert property (@(posedge clk) disable iff (!rst_n) !$fell(unk_r))
    else $error("unknown flag cleared");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(flags_r))
    else $error("compare flags not one-hot");
  a_div_nomem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (!mem_we && !mem_re))
    else $error("memory access during divide");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r != S_IDLE))
    else $error("item popped but sequencer stayed idle");
`endif

endmodule

// ===== rtl/ttk91_instruction_execute.sv =====
// TTK-91 execute unit: front end decodes, a two-entry queue decouples, back end executes.
// Memory indirection, div/mod, pushr, popr, call, exit and pop add sequencer states
// to those of a register op; a preload goes straight to the result.
// The back end holds one item at a time and pops the next only after the last result
// has been registered on the result channel.
// Reset (synchronous, active low) clears registers, PC, flags; data memory is not cleared.
module ttk91_instruction_execute #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  ttk_in_if.sink    in_ch,
  ttk_out_if.source out_ch
);

  logic           push, q_ready, pop, q_valid;
  ttk_pkg::item_t push_item, q_item;

  ttk_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push(push), .push_item(push_item), .q_ready(q_ready)
  );

  ttk_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .q_ready(q_ready),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  ttk_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the TTK-91 execute unit: drives instruction and
// preload items and compares every result against a scoreboard predictor.
// Depends on ttk_pkg, ttk_in_if, ttk_out_if and ttk91_instruction_execute.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_ALT = 2'd3;
  localparam logic       OPER_EXEC = 1'b0;
  localparam logic       OPER_PRELOAD = 1'b1;
  localparam int         IDLE_LIMIT = 5000;
  localparam int         RANDOM_ITEMS = 860;

  typedef struct {
    logic        operation;
    logic [31:0] word;
    logic [31:0] in_value;
    logic [9:0]  pl_addr;
    logic [31:0] pl_data;
  } stim_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic        out_valid;
    logic [31:0] out_value;
    logic        halted;
    logic        g, e, l;
    logic        unk;
    logic        dbz;
  } res_t;

  class ttk_scoreboard;
    logic [31:0] regs[8];
    logic [9:0]  pc;
    logic [2:0]  flags;
    logic        unk, halt;
    logic [31:0] mem[1024];
    bit          written[1024];
    res_t        expected_q[$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (written[i]) written[i] = 0;
      pc = '0; flags = '0; unk = 0; halt = 0; errors = 0;
    endfunction

    function logic [31:0] rd(logic [31:0] a);
      return mem[a[9:0]];
    endfunction

    function void wr(logic [31:0] a, logic [31:0] v);
      mem[a[9:0]] = v;
      written[a[9:0]] = 1;
    endfunction

    function logic [31:0] sext(logic [31:0] w);
      return {{16{w[15]}}, w[15:0]};
    endfunction

    function bit reads_ok(stim_t s);
      ttk_pkg::opc_t op;
      logic [1:0]    mode;
      logic [2:0]    ri;
      logic [31:0]   x;
      if (s.operation == OPER_PRELOAD || halt) return 1;
      op = s.word[31:24]; mode = s.word[20:19]; ri = s.word[18:16];
      x = sext(s.word) + ((ri != 0) ? regs[ri] : 32'd0);
      if (mode == ttk_pkg::MODE_DIR || mode == ttk_pkg::MODE_IND) begin
        if (!written[x[9:0]]) return 0;
        x = rd(x);
      end
      if (mode == ttk_pkg::MODE_IND && !written[x[9:0]]) return 0;
      if (op == ttk_pkg::OP_EXIT)
        return written[regs[ttk_pkg::FP_IDX][9:0] - 10'd1] &&
               written[regs[ttk_pkg::FP_IDX][9:0]];
      if (op == ttk_pkg::OP_POP) return written[regs[ttk_pkg::SP_IDX][9:0]];
      if (op == ttk_pkg::OP_POPR) begin
        for (int k = 0; k < 6; k++)
          if (!written[regs[ttk_pkg::SP_IDX][9:0] - k[9:0]]) return 0;
      end
      return 1;
    endfunction

    function void note(stim_t s);
      res_t          r;
      ttk_pkg::opc_t op;
      logic [2:0]    rj, ri;
      logic [1:0]    mode;
      logic [31:0]   x, a, ma, mx, q, m, fp;
      logic [2:0]    f;
      r.out_valid = 0; r.out_value = '0; r.dbz = 0;
      if (s.operation == OPER_PRELOAD) begin
        wr({22'd0, s.pl_addr}, s.pl_data);
      end else if (!halt) begin
        op = s.word[31:24]; rj = s.word[23:21]; mode = s.word[20:19]; ri = s.word[18:16];
        x = sext(s.word) + ((ri != 0) ? regs[ri] : 32'd0);
        if (mode == ttk_pkg::MODE_DIR) x = rd(x);
        else if (mode == ttk_pkg::MODE_IND) x = rd(rd(x));
        pc = pc + 10'd1;
        f = flags;
        a = regs[rj];
        case (op)
          ttk_pkg::OP_NOP: ;
          ttk_pkg::OP_STORE: wr(x, regs[rj]);
          ttk_pkg::OP_LOAD: regs[rj] = x;
          ttk_pkg::OP_IN: regs[rj] = s.in_value;
          ttk_pkg::OP_OUT: begin r.out_valid = 1; r.out_value = regs[rj]; end
          ttk_pkg::OP_ADD: regs[rj] = a + x;
          ttk_pkg::OP_SUB: regs[rj] = a - x;
          ttk_pkg::OP_MUL: regs[rj] = a * x;
          ttk_pkg::OP_DIV, ttk_pkg::OP_MOD: begin
            if (x == 0) r.dbz = 1;
            else begin
              ma = a[31] ? -a : a;
              mx = x[31] ? -x : x;
              q = ma / mx; m = ma % mx;
              if (op == ttk_pkg::OP_DIV) regs[rj] = (a[31] != x[31]) ? -q : q;
              else regs[rj] = a[31] ? -m : m;
            end
          end
          ttk_pkg::OP_AND: regs[rj] = a & x;
          ttk_pkg::OP_OR: regs[rj] = a | x;
          ttk_pkg::OP_XOR: regs[rj] = a ^ x;
          ttk_pkg::OP_SHL: regs[rj] = (x >= 32) ? 32'd0 : a << x[4:0];
          ttk_pkg::OP_SHR: regs[rj] = (x >= 32) ? 32'd0 : a >> x[4:0];
          ttk_pkg::OP_NOT: regs[rj] = ~a;
          ttk_pkg::OP_SHRA:
            regs[rj] = $unsigned($signed(a) >>> ((x >= 32) ? 5'd31 : x[4:0]));
          ttk_pkg::OP_COMP: begin
            if ($signed(a) > $signed(x)) flags = 3'b100;
            else if (a == x) flags = 3'b010;
            else flags = 3'b001;
          end
          ttk_pkg::OP_JUMP: pc = x[9:0];
          ttk_pkg::OP_JNEG: if (a[31]) pc = x[9:0];
          ttk_pkg::OP_JZER: if (a == 0) pc = x[9:0];
          ttk_pkg::OP_JPOS: if (!a[31] && a != 0) pc = x[9:0];
          ttk_pkg::OP_JNNEG: if (!a[31]) pc = x[9:0];
          ttk_pkg::OP_JNZER: if (a != 0) pc = x[9:0];
          ttk_pkg::OP_JNPOS: if (a[31] || a == 0) pc = x[9:0];
          ttk_pkg::OP_JLES: if (f[0]) pc = x[9:0];
          ttk_pkg::OP_JEQU: if (f[1]) pc = x[9:0];
          ttk_pkg::OP_JGRE: if (f[2]) pc = x[9:0];
          ttk_pkg::OP_JNLES: if (!f[0]) pc = x[9:0];
          ttk_pkg::OP_JNEQU: if (!f[1]) pc = x[9:0];
          ttk_pkg::OP_JNGRE: if (!f[2]) pc = x[9:0];
          ttk_pkg::OP_CALL: begin
            regs[ttk_pkg::SP_IDX] += 1;
            wr(regs[ttk_pkg::SP_IDX], {22'd0, pc});
            regs[ttk_pkg::SP_IDX] += 1;
            wr(regs[ttk_pkg::SP_IDX], regs[ttk_pkg::FP_IDX]);
            pc = x[9:0];
            regs[ttk_pkg::FP_IDX] = regs[ttk_pkg::SP_IDX];
          end
          ttk_pkg::OP_EXIT: begin
            fp = regs[ttk_pkg::FP_IDX];
            regs[ttk_pkg::SP_IDX] = fp - 32'd2 - x;
            pc = 10'(rd(fp - 32'd1));
            regs[ttk_pkg::FP_IDX] = rd(fp);
          end
          ttk_pkg::OP_PUSH: begin
            regs[ttk_pkg::SP_IDX] += 1;
            wr(regs[ttk_pkg::SP_IDX], x);
          end
          ttk_pkg::OP_POP: begin
            regs[ri] = rd(regs[ttk_pkg::SP_IDX]);
            regs[ttk_pkg::SP_IDX] -= 1;
          end
          ttk_pkg::OP_PUSHR:
            for (int k = 0; k < 6; k++) begin
              regs[ttk_pkg::SP_IDX] += 1;
              wr(regs[ttk_pkg::SP_IDX], regs[k]);
            end
          ttk_pkg::OP_POPR:
            for (int k = 5; k >= 0; k--) begin
              regs[k] = rd(regs[ttk_pkg::SP_IDX]);
              regs[ttk_pkg::SP_IDX] -= 1;
            end
          ttk_pkg::OP_SVC: if (s.word[15:0] == ttk_pkg::HALT_CODE) halt = 1;
          default: unk = 1;
        endcase
      end
      r.next_pc = pc; r.halted = halt;
      r.g = flags[2]; r.e = flags[1]; r.l = flags[0]; r.unk = unk;
      expected_q.push_back(r);
    endfunction

    function void check(res_t got);
      res_t w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: pc=%0d", got.next_pc);
        return;
      end
      w = expected_q.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp pc=%0d ov=%b val=%h h=%b gel=%b%b%b u=%b dz=%b",
                   w.next_pc, w.out_valid, w.out_value, w.halted, w.g, w.e, w.l, w.unk,
                   w.dbz);
          $display("          got pc=%0d ov=%b val=%h h=%b gel=%b%b%b u=%b dz=%b",
                   got.next_pc, got.out_valid, got.out_value, got.halted, got.g,
                   got.e, got.l, got.unk, got.dbz);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  ttk_in_if  in_ch();
  ttk_out_if out_ch();
  ttk91_instruction_execute DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  ttk_scoreboard sb = new();
  int   idle_phase = 0;
  int   n_sent = 0;
  int   quiet_cycles = 0;
  ttk_pkg::opc_t op_list[$] = '{
    ttk_pkg::OP_NOP, ttk_pkg::OP_STORE, ttk_pkg::OP_LOAD, ttk_pkg::OP_IN,
    ttk_pkg::OP_OUT, ttk_pkg::OP_ADD, ttk_pkg::OP_SUB, ttk_pkg::OP_MUL,
    ttk_pkg::OP_DIV, ttk_pkg::OP_MOD, ttk_pkg::OP_AND, ttk_pkg::OP_OR,
    ttk_pkg::OP_XOR, ttk_pkg::OP_SHL, ttk_pkg::OP_SHR, ttk_pkg::OP_NOT,
    ttk_pkg::OP_SHRA, ttk_pkg::OP_COMP, ttk_pkg::OP_JUMP, ttk_pkg::OP_JNEG,
    ttk_pkg::OP_JZER, ttk_pkg::OP_JPOS, ttk_pkg::OP_JNNEG, ttk_pkg::OP_JNZER,
    ttk_pkg::OP_JNPOS, ttk_pkg::OP_JLES, ttk_pkg::OP_JEQU, ttk_pkg::OP_JGRE,
    ttk_pkg::OP_JNLES, ttk_pkg::OP_JNEQU, ttk_pkg::OP_JNGRE, ttk_pkg::OP_CALL,
    ttk_pkg::OP_EXIT, ttk_pkg::OP_PUSH, ttk_pkg::OP_POP, ttk_pkg::OP_PUSHR,
    ttk_pkg::OP_POPR, ttk_pkg::OP_SVC};
  logic [31:0] plan_q[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic stim_t preload(logic [9:0] a, logic [31:0] d);
    stim_t s;
    s.operation = OPER_PRELOAD; s.word = $urandom(); s.in_value = $urandom();
    s.pl_addr = a; s.pl_data = d;
    return s;
  endfunction

  function automatic stim_t exec_word(logic [31:0] w);
    stim_t s;
    s.operation = OPER_EXEC; s.word = w; s.in_value = $urandom();
    s.pl_addr = 10'($urandom()); s.pl_data = $urandom();
    return s;
  endfunction

  function automatic logic [31:0] mk(ttk_pkg::opc_t op, logic [2:0] rj, logic [1:0] mode,
                                     logic [2:0] ri, logic [15:0] addr);
    return {op, rj, mode, ri, addr};
  endfunction

  function automatic logic [31:0] random_word(bit allow_halt);
    ttk_pkg::opc_t op;
    logic [15:0]   addr;
    logic [1:0]    mode;
    op = ($urandom_range(99) < 90) ? op_list[$urandom_range(op_list.size() - 1)]
                                   : ttk_pkg::opc_t'($urandom());
    case ($urandom_range(3))
      0, 1: addr = 16'($urandom_range(63));
      2: addr = 16'($urandom());
      default: addr = 16'hffff - 16'($urandom_range(40));
    endcase
    mode = ($urandom_range(99) < 55) ? MODE_IMM : 2'($urandom());
    if (op == ttk_pkg::OP_SVC && addr == ttk_pkg::HALT_CODE && !allow_halt)
      addr = addr + 16'd1;
    return mk(op, 3'($urandom()), mode, ($urandom_range(99) < 50) ? 3'd0 : 3'($urandom()),
              addr);
  endfunction

  task automatic fill_plan();
    logic [15:0] base;
    base = 16'($urandom_range(100, 900));
    case ($urandom_range(9))
      0: begin
        plan_q.push_back(mk(ttk_pkg::OP_LOAD, ttk_pkg::SP_IDX, MODE_IMM, 3'd0, base));
        plan_q.push_back(mk(ttk_pkg::OP_PUSHR, 3'($urandom()), MODE_IMM, 3'd0,
                            16'($urandom())));
        plan_q.push_back(random_word(0));
        plan_q.push_back(mk(ttk_pkg::OP_POPR, 3'($urandom()), MODE_IMM, 3'd0,
                            16'($urandom())));
      end
      1: begin
        plan_q.push_back(mk(ttk_pkg::OP_LOAD, ttk_pkg::SP_IDX, MODE_IMM, 3'd0, base));
        plan_q.push_back(mk(ttk_pkg::OP_CALL, 3'($urandom()), MODE_IMM, 3'd0,
                            16'($urandom())));
        plan_q.push_back(mk(ttk_pkg::OP_PUSH, 3'($urandom()), MODE_IMM, 3'($urandom()),
                            16'($urandom())));
        plan_q.push_back(mk(ttk_pkg::OP_POP, 3'($urandom()), MODE_IMM, 3'($urandom()),
                            16'd0));
        plan_q.push_back(mk(ttk_pkg::OP_EXIT, 3'($urandom()), MODE_IMM, 3'd0,
                            16'($urandom_range(3))));
      end
      2: begin
        plan_q.push_back(mk(ttk_pkg::OP_COMP, 3'($urandom()), 2'($urandom()),
                            3'($urandom()), 16'($urandom())));
        plan_q.push_back(mk(ttk_pkg::opc_t'(ttk_pkg::OP_JLES + $urandom_range(5)),
                            3'($urandom()), MODE_IMM, 3'd0, 16'($urandom())));
      end
      default: plan_q.push_back(random_word(0));
    endcase
  endtask

  task automatic send_item(stim_t s);
    int idle_pct;
    idle_pct = (idle_phase == 1) ? 64 : (idle_phase == 3) ? 11 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= s.operation;
    in_ch.instr_word <= s.word;
    in_ch.in_value <= s.in_value;
    in_ch.preload_addr <= s.pl_addr;
    in_ch.preload_data <= s.pl_data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(s);
    n_sent++;
    idle_phase = (n_sent / 120) % 4;
  endtask

  task automatic send_safe(stim_t s);
    int tries;
    tries = 0;
    while (!sb.reads_ok(s) && tries < 20) begin
      s = exec_word(random_word(0));
      tries++;
    end
    if (!sb.reads_ok(s)) s = exec_word(mk(ttk_pkg::OP_NOP, 3'd0, MODE_IMM, 3'd0, 16'd0));
    send_item(s);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OPER_EXEC;
    in_ch.instr_word <= '0;
    in_ch.in_value <= '0;
    in_ch.preload_addr <= '0;
    in_ch.preload_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(preload(10'd0, 32'h7fffffff));
    send_item(preload(10'd1, 32'h80000000));
    send_item(preload(10'd2, 32'd5));
    send_item(preload(10'd6, 32'd2));
    send_item(preload(10'd1023, 32'hffffffff));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd1, MODE_IMM, 3'd0, 16'h8000)));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd2, ttk_pkg::MODE_DIR, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd3, ttk_pkg::MODE_IND, 3'd0, 16'd6)));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd5, MODE_ALT, 3'd0, 16'd6)));
    send_item(exec_word(mk(ttk_pkg::OP_ADD, 3'd2, MODE_IMM, 3'd0, 16'd1)));
    send_item(exec_word(mk(ttk_pkg::OP_DIV, 3'd3, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd4, ttk_pkg::MODE_DIR, 3'd0, 16'hffff)));
    send_item(exec_word(mk(ttk_pkg::OP_LOAD, 3'd4, ttk_pkg::MODE_DIR, 3'd0, 16'd1)));
    send_item(exec_word(mk(ttk_pkg::OP_DIV, 3'd4, MODE_IMM, 3'd0, 16'hffff)));
    send_item(exec_word(mk(ttk_pkg::OP_MOD, 3'd2, MODE_IMM, 3'd0, 16'hffff)));
    send_item(exec_word(mk(ttk_pkg::OP_SHRA, 3'd1, MODE_IMM, 3'd0, 16'd40)));
    send_item(exec_word(mk(ttk_pkg::OP_SHL, 3'd3, MODE_IMM, 3'd0, 16'd40)));
    send_item(exec_word(mk(ttk_pkg::OP_COMP, 3'd1, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_JLES, 3'd0, MODE_IMM, 3'd0, 16'hfff0)));
    send_item(exec_word(mk(ttk_pkg::OP_IN, 3'd5, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_OUT, 3'd5, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_CALL, 3'd0, MODE_IMM, 3'd0, 16'd500)));
    send_item(exec_word(mk(ttk_pkg::OP_EXIT, 3'd0, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(8'hff, 3'd0, MODE_IMM, 3'd0, 16'd0)));
    send_item(exec_word(mk(ttk_pkg::OP_SVC, 3'd0, MODE_IMM, 3'd0, 16'd12)));

    for (int a = 0; a < 64; a++)
      send_item(preload(10'(a), ($urandom_range(1)) ? 32'($urandom_range(63)) : $urandom()));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 15) begin
        send_item(preload(10'($urandom()),
                          ($urandom_range(1)) ? 32'($urandom_range(63)) : $urandom()));
      end else begin
        if (plan_q.size() == 0) fill_plan();
        send_safe(exec_word(plan_q.pop_front()));
      end
    end
    send_item(exec_word(mk(ttk_pkg::OP_SVC, 3'($urandom()), MODE_IMM, 3'd0,
                           ttk_pkg::HALT_CODE)));
    for (int n = 0; n < 6; n++) begin
      if (n == 3) send_item(preload(10'($urandom()), $urandom()));
      else send_item(exec_word(random_word(1)));
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ttk91_instruction_execute regression: pass");
    end else begin
      $display("ttk91_instruction_execute regression: fail");
    end
    $finish;
  end

  initial begin
    int stall_pct;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall_pct = (idle_phase == 2) ? 64 : (idle_phase == 3) ? 11 : 0;
      out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.next_pc = out_ch.next_pc;
      got.out_valid = out_ch.out_valid;
      got.out_value = out_ch.out_value;
      got.halted = out_ch.halted;
      got.g = out_ch.flag_greater;
      got.e = out_ch.flag_equal;
      got.l = out_ch.flag_less;
      got.unk = out_ch.unknown_opcode;
      got.dbz = out_ch.divide_by_zero;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("ttk91_instruction_execute regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
rtl/ttk_pkg.sv
rtl/ttk_in_if.sv
rtl/ttk_out_if.sv
rtl/ttk_front.sv
rtl/ttk_queue.sv
rtl/ttk_back.sv
rtl/ttk91_instruction_execute.sv
bench/tb_top.sv
